// ----- sv/wrl_pkg.sv -----
// Shared widths and constants for the windowed rate limiter.
// No dependencies; every other file imports this package.
`default_nettype none

package wrl_pkg;

   localparam int WINDOW_MESSAGES = 10;
   localparam int IDX_W   = (WINDOW_MESSAGES > 1) ? $clog2(WINDOW_MESSAGES) : 1;
   localparam int SIZE_W  = 17;
   localparam int BYTES_W = 16;
   localparam int RATE_W  = 20;
   localparam int WORD_W  = 32;
   localparam int CNT_W   = $clog2(WORD_W);
   localparam int SUM_W   = BYTES_W + IDX_W + 1;
   localparam int CMP_W   = (SUM_W > RATE_W) ? SUM_W : RATE_W;
   localparam int PROD_W  = BYTES_W + 10;

   localparam logic [IDX_W:0]     WIN_EXT      = (IDX_W + 1)'(WINDOW_MESSAGES);
   localparam logic [IDX_W-1:0]   LAST_SLOT    = IDX_W'(WINDOW_MESSAGES - 1);
   localparam logic [CNT_W-1:0]   MOD_LAST     = CNT_W'(WORD_W - 1);
   localparam logic [CNT_W-1:0]   DIV_LAST     = CNT_W'(PROD_W - 1);
   localparam logic [SIZE_W-1:0]  NOTHING_SENT = {SIZE_W{1'b1}};

   localparam logic CMD_CHECK  = 1'b0;
   localparam logic CMD_RECORD = 1'b1;

endpackage

`default_nettype wire

// ----- sv/wrl_req_if.sv -----
// Request channel of the rate limiter: valid/ready plus command fields.
// Depends on wrl_pkg.
`default_nettype none

interface wrl_req_if import wrl_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [WORD_W-1:0]        frame_number;
   logic signed [SIZE_W-1:0] sent_size;
   logic [WORD_W-1:0]        now_ms;

   modport source (output valid, command, frame_number, sent_size, now_ms, input ready);
   modport sink   (input valid, command, frame_number, sent_size, now_ms, output ready);
endinterface

`default_nettype wire

// ----- sv/wrl_rsp_if.sv -----
// Response channel of the rate limiter: valid/ready plus result fields.
// Depends on wrl_pkg.
`default_nettype none

interface wrl_rsp_if import wrl_pkg::*;;
   logic              valid;
   logic              ready;
   logic              drop;
   logic [WORD_W-1:0] send_time;
   logic [WORD_W-1:0] suppress_count;

   modport source (output valid, drop, send_time, suppress_count, input ready);
   modport sink   (input valid, drop, send_time, suppress_count, output ready);
endinterface

`default_nettype wire

// ----- sv/windowed_rate_limiter_core.sv -----
// Per-peer sliding-window bandwidth limiter, single module.
// Depends on wrl_pkg, wrl_req_if and wrl_rsp_if.
//
// Usage:
//   req_chan  : one request per frame event, command 0 = window check,
//               command 1 = record a sent size (-1 = nothing sent).
//   rsp_chan  : one response per request: drop flag, stored send time,
//               running suppression count.
//   csr_*     : write the 20-bit rate in bytes/s; 0 selects loopback.
// Operation: the slot index is frame_number mod window, found by a serial
//   remainder one frame bit per cycle. A check then walks the ring one slot
//   per cycle and compares. A record divides size*1000 by the rate with a
//   restoring divider, one quotient bit per cycle. The next request can be
//   accepted in the cycle after the response is loaded.
// One request is in flight at a time; req_chan.ready is high only when idle.
// The response sits in an output register; if rsp_chan is stalled the next
//   request may be accepted and computed, finishing once the register frees.
// Reset (synchronous) clears the ring, suppression count, send time and rate.
`default_nettype none

module windowed_rate_limiter_core import wrl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [RATE_W-1:0] csr_write_data,
   wrl_req_if.sink                req_chan,
   wrl_rsp_if.source              rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MOD, ST_SUM, ST_CMP, ST_DIV, ST_ADD, ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic                     cmd_ff, cmd_in;
   logic [WORD_W-1:0]        frame_ff, frame_in;
   logic [SIZE_W-1:0]        size_ff, size_in;
   logic [WORD_W-1:0]        now_ff, now_in;
   logic [IDX_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [BYTES_W-1:0]       ring_ff [WINDOW_MESSAGES];
   logic [BYTES_W-1:0]       ring_in [WINDOW_MESSAGES];
   logic [PROD_W-1:0]        div_ff, div_in;
   logic [RATE_W-1:0]        drem_ff, drem_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [WORD_W-1:0]        supp_ff, supp_in;
   logic [WORD_W-1:0]        send_ff, send_in;
   logic                     drop_ff, drop_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_drop_ff, rsp_drop_in;
   logic [WORD_W-1:0]        rsp_send_ff, rsp_send_in;
   logic [WORD_W-1:0]        rsp_supp_ff, rsp_supp_in;

   logic                     req_fire;
   logic [IDX_W:0]           rem_shift;
   logic [IDX_W-1:0]         rem_next;
   logic [RATE_W:0]          d_shift;
   logic [RATE_W:0]          d_sub;
   logic                     d_ge;
   logic [BYTES_W-1:0]       bytes;
   logic [PROD_W-1:0]        b_ext;
   logic [PROD_W-1:0]        prod;

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign req_fire                = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drop           = rsp_drop_ff;
   assign rsp_chan.send_time      = rsp_send_ff;
   assign rsp_chan.suppress_count = rsp_supp_ff;

   // serial remainder, one frame bit per cycle
   assign rem_shift = {rem_ff, frame_ff[WORD_W-1]};
   assign rem_next  = (rem_shift >= WIN_EXT) ? IDX_W'(rem_shift - WIN_EXT)
                                             : IDX_W'(rem_shift);

   // restoring divide, one quotient bit per cycle
   assign d_shift = {drem_ff, div_ff[PROD_W-1]};
   assign d_sub   = d_shift - {1'b0, rate_ff};
   assign d_ge    = (d_shift >= {1'b0, rate_ff});

   // negative sizes saturate to zero; x1000 = x1024 - x32 + x8
   assign bytes = size_ff[SIZE_W-1] ? '0 : size_ff[BYTES_W-1:0];
   assign b_ext = PROD_W'(bytes);
   assign prod  = (b_ext << 10) - (b_ext << 5) + (b_ext << 3);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      frame_in     = frame_ff;
      size_in      = size_ff;
      now_in       = now_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      ring_in      = ring_ff;
      div_in       = div_ff;
      drem_in      = drem_ff;
      rate_in      = csr_write_enable ? csr_write_data : rate_ff;
      supp_in      = supp_ff;
      send_in      = send_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_drop_in  = rsp_drop_ff;
      rsp_send_in  = rsp_send_ff;
      rsp_supp_in  = rsp_supp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_chan.command;
               frame_in = req_chan.frame_number;
               size_in  = req_chan.sent_size;
               now_in   = req_chan.now_ms;
               rem_in   = '0;
               cnt_in   = '0;
               drop_in  = 1'b0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            frame_in = {frame_ff[WORD_W-2:0], 1'b0};
            rem_in   = rem_next;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MOD_LAST) begin
               cnt_in = '0;
               if (cmd_ff == CMD_CHECK) begin
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = (rate_ff == '0) ? ST_DONE : ST_SUM;
               end else if (size_ff == NOTHING_SENT) begin
                  state_in = ST_DONE;
               end else if (rate_ff == '0) begin
                  send_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  ring_in[rem_next] = bytes;
                  div_in            = prod;
                  drem_in           = '0;
                  state_in          = ST_DIV;
               end
            end
         end
         ST_SUM: begin
            sum_in = sum_ff + SUM_W'(ring_ff[idx_ff]);
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_CMP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CMP: begin
            if (CMP_W'(sum_ff) > CMP_W'(rate_ff)) begin
               drop_in         = 1'b1;
               supp_in         = supp_ff + 1'b1;
               ring_in[rem_ff] = '0;
            end
            state_in = ST_DONE;
         end
         ST_DIV: begin
            div_in  = {div_ff[PROD_W-2:0], d_ge};
            drem_in = d_ge ? d_sub[RATE_W-1:0] : d_shift[RATE_W-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            send_in  = now_ff + WORD_W'(div_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_drop_in  = drop_ff;
               rsp_send_in  = send_ff;
               rsp_supp_in  = supp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ring_ff      <= '{default: '0};
         rate_ff      <= '0;
         supp_ff      <= '0;
         send_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_ff      <= ring_in;
         rate_ff      <= rate_in;
         supp_ff      <= supp_in;
         send_ff      <= send_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      frame_ff    <= frame_in;
      size_ff     <= size_in;
      now_ff      <= now_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      div_ff      <= div_in;
      drem_ff     <= drem_in;
      drop_ff     <= drop_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_send_ff <= rsp_send_in;
      rsp_supp_ff <= rsp_supp_in;
   end

endmodule

`default_nettype wire
